[design/software_timer_task_table_assert.svh]
// assertion macros used by the timer table top level
`ifndef SOFTWARE_TIMER_TASK_TABLE_ASSERT_SVH
`define SOFTWARE_TIMER_TASK_TABLE_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/stt_pkg.sv]
// shared types, codes and constants of the software timer task table
package stt_pkg;

  // table depth default
  localparam int unsigned MaxTasksDefault = 8;

  // field widths
  localparam int unsigned IdW    = 8;
  localparam int unsigned DelayW = 16;
  localparam int unsigned CountW = 18;
  localparam int unsigned StatW  = 3;

  // saturation point of the tick counter
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // operation codes
  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_STOP     = 2'd1,
    OP_TICK     = 2'd2,
    OP_DISPATCH = 2'd3
  } stt_op_e;

  // status codes
  localparam logic [StatW-1:0] StOk       = 3'd0;
  localparam logic [StatW-1:0] StTimeout  = 3'd1;
  localparam logic [StatW-1:0] StEmpty    = 3'd2;
  localparam logic [StatW-1:0] StFull     = 3'd3;
  localparam logic [StatW-1:0] StNotFound = 3'd4;

  // one timer entry as held in the table
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [DelayW-1:0] delay;
    logic              periodic;
    logic [CountW-1:0] count;
  } stt_entry_t;

  // verdict of the shared evaluation unit on one entry
  typedef struct packed {
    logic [CountW-1:0] count_inc;
    logic              due;
    logic              late;
    logic              id_match;
  } stt_eval_t;

endpackage

[design/stt_table.sv]
// timer entry memory: one write port, two registered read ports
module stt_table #(
  parameter int unsigned MAX_TASKS = stt_pkg::MaxTasksDefault,
  localparam int unsigned IdxW = $clog2(MAX_TASKS)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  stt_pkg::stt_entry_t wdata_i,
  input  logic [IdxW-1:0]     raddr_a_i,
  input  logic [IdxW-1:0]     raddr_b_i,
  output stt_pkg::stt_entry_t rdata_a_o,
  output stt_pkg::stt_entry_t rdata_b_o
);

  stt_pkg::stt_entry_t mem_q [MAX_TASKS];
  stt_pkg::stt_entry_t rdata_a_q;
  stt_pkg::stt_entry_t rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[design/stt_unit.sv]
// shared evaluation unit: saturating increment, due and late compares, id match
module stt_unit (
  input  stt_pkg::stt_entry_t     entry_i,
  input  logic [stt_pkg::IdW-1:0] id_i,
  output stt_pkg::stt_eval_t      eval_o
);

  logic [stt_pkg::CountW-1:0] delay_ext;
  logic [stt_pkg::CountW-1:0] delay_dbl;

  // delay widened, and doubled by a shift
  assign delay_ext = {2'b00, entry_i.delay};
  assign delay_dbl = {1'b0, entry_i.delay, 1'b0};

  // counter step that holds at the top
  assign eval_o.count_inc = (entry_i.count == stt_pkg::CountMax) ? entry_i.count
                                                                 : entry_i.count + 1'b1;

  // firing and timeout tests
  assign eval_o.due  = (entry_i.count >= delay_ext);
  assign eval_o.late = (entry_i.count > delay_dbl);

  // stop lookup
  assign eval_o.id_match = (entry_i.id == id_i);

endmodule

[design/software_timer_task_table.sv]
// top level of the software timer task table: sequencer, ring pointers, result register
//
// channel   direction  handshake                  payload
// command   in         start high, busy low       operation_i task_id_i delay_ticks_i periodic_i
// result    out        result_valid_o, 1 cycle    fired_id_o fired_o status_o last_o
//
// start completes in the idle state; stop walks the ring until its first match, tick walks
// every entry, and dispatch with a pending tick walks every entry and then a flush step; each
// entry visited takes a read state, then an evaluate and write back state, on the table memory.
// each result appears in the cycle after the edge that produced it, for one cycle only.
// the receiver cannot stall; busy is high for the whole walk and no command is taken then.
// reset clears pointers, full and tick flags at once; table contents need no clearing pass.
`include "software_timer_task_table_assert.svh"

module software_timer_task_table #(
  parameter int unsigned MAX_TASKS = stt_pkg::MaxTasksDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 operation_i,
  input  logic [stt_pkg::IdW-1:0]    task_id_i,
  input  logic [stt_pkg::DelayW-1:0] delay_ticks_i,
  input  logic                       periodic_i,
  output logic                       result_valid_o,
  output logic [stt_pkg::IdW-1:0]    fired_id_o,
  output logic                       fired_o,
  output logic [stt_pkg::StatW-1:0]  status_o,
  output logic                       last_o
);

  localparam int unsigned IdxW = $clog2(MAX_TASKS);
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_TASKS - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_FLUSH = 4'b1000
  } stt_state_e;

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] x);
    if (x == LastIdx) begin
      return '0;
    end else begin
      return x + 1'b1;
    end
  endfunction

  stt_state_e                 state_q, state_d;
  stt_pkg::stt_op_e           op_q, op_d;
  logic [IdxW-1:0]            head_q, head_d;
  logic [IdxW-1:0]            tail_q, tail_d;
  logic                       full_q, full_d;
  logic                       pend_q, pend_d;
  logic [IdxW-1:0]            slot_q, slot_d;
  logic [CntW-1:0]            rem_q, rem_d;
  logic [stt_pkg::IdW-1:0]    id_q, id_d;
  logic                       hold_valid_q, hold_valid_d;
  logic [stt_pkg::IdW-1:0]    hold_id_q, hold_id_d;
  logic [stt_pkg::StatW-1:0]  hold_status_q, hold_status_d;
  logic                       rv_q, rv_d;
  logic [stt_pkg::IdW-1:0]    fid_q, fid_d;
  logic                       fired_q, fired_d;
  logic [stt_pkg::StatW-1:0]  status_q, status_d;
  logic                       last_q, last_d;

  logic                       we_c;
  logic [IdxW-1:0]            waddr_c;
  stt_pkg::stt_entry_t        wdata_c;
  stt_pkg::stt_entry_t        rdata_a;
  stt_pkg::stt_entry_t        rdata_b;
  stt_pkg::stt_eval_t         eval;
  logic [CntW-1:0]            occ_c;
  logic                       last_step;

  // entry memory: port a follows the walk, port b always the tail
  stt_table #(
    .MAX_TASKS(MAX_TASKS)
  ) u_table (
    .clk_i    (clk_i),
    .we_i     (we_c),
    .waddr_i  (waddr_c),
    .wdata_i  (wdata_c),
    .raddr_a_i(slot_q),
    .raddr_b_i(tail_q),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  // shared compare and increment unit
  stt_unit u_unit (
    .entry_i(rdata_a),
    .id_i   (id_q),
    .eval_o (eval)
  );

  // ring occupancy
  always_comb begin
    if (full_q) begin
      occ_c = CntW'(MAX_TASKS);
    end else if (head_q >= tail_q) begin
      occ_c = CntW'(head_q - tail_q);
    end else begin
      occ_c = CntW'(MAX_TASKS) - CntW'(tail_q) + CntW'(head_q);
    end
  end

  assign last_step = (rem_q == CntW'(1));
  assign busy      = (state_q != S_IDLE);

  // sequencer
  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    head_d        = head_q;
    tail_d        = tail_q;
    full_d        = full_q;
    pend_d        = pend_q;
    slot_d        = slot_q;
    rem_d         = rem_q;
    id_d          = id_q;
    hold_valid_d  = hold_valid_q;
    hold_id_d     = hold_id_q;
    hold_status_d = hold_status_q;
    rv_d          = 1'b0;
    fid_d         = '0;
    fired_d       = 1'b0;
    status_d      = stt_pkg::StOk;
    last_d        = 1'b0;
    we_c          = 1'b0;
    waddr_c       = slot_q;
    wdata_c       = rdata_a;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d   = stt_pkg::stt_op_e'(operation_i);
          slot_d = tail_q;
          rem_d  = occ_c;
          id_d   = task_id_i;
          case (stt_pkg::stt_op_e'(operation_i))
            stt_pkg::OP_START: begin
              rv_d   = 1'b1;
              last_d = 1'b1;
              if (full_q) begin
                status_d = stt_pkg::StFull;
              end else begin
                we_c             = 1'b1;
                waddr_c          = head_q;
                wdata_c.id       = task_id_i;
                wdata_c.delay    = delay_ticks_i;
                wdata_c.periodic = periodic_i;
                wdata_c.count    = '0;
                head_d           = idx_inc(head_q);
                if (idx_inc(head_q) == tail_q) begin
                  full_d = 1'b1;
                end
              end
            end
            stt_pkg::OP_STOP: begin
              if (occ_c == '0) begin
                rv_d     = 1'b1;
                last_d   = 1'b1;
                status_d = stt_pkg::StNotFound;
              end else begin
                state_d = S_READ;
              end
            end
            stt_pkg::OP_TICK: begin
              pend_d = 1'b1;
              if (occ_c == '0) begin
                rv_d   = 1'b1;
                last_d = 1'b1;
              end else begin
                state_d = S_READ;
              end
            end
            stt_pkg::OP_DISPATCH: begin
              hold_valid_d = 1'b0;
              if (!pend_q) begin
                rv_d   = 1'b1;
                last_d = 1'b1;
              end else if (occ_c == '0) begin
                pend_d   = 1'b0;
                rv_d     = 1'b1;
                last_d   = 1'b1;
                status_d = stt_pkg::StEmpty;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_READ: begin
        state_d = S_EXEC;
      end

      S_EXEC: begin
        rem_d   = rem_q - 1'b1;
        slot_d  = idx_inc(slot_q);
        state_d = last_step ? S_IDLE : S_READ;
        case (op_q)
          // bump the counter of this entry
          stt_pkg::OP_TICK: begin
            we_c          = 1'b1;
            wdata_c.count = eval.count_inc;
            if (last_step) begin
              rv_d   = 1'b1;
              last_d = 1'b1;
            end
          end
          // first match is replaced by the tail entry
          stt_pkg::OP_STOP: begin
            if (eval.id_match) begin
              we_c    = 1'b1;
              wdata_c = rdata_b;
              tail_d  = idx_inc(tail_q);
              full_d  = 1'b0;
              rv_d    = 1'b1;
              last_d  = 1'b1;
              state_d = S_IDLE;
            end else if (last_step) begin
              rv_d     = 1'b1;
              last_d   = 1'b1;
              status_d = stt_pkg::StNotFound;
            end
          end
          // fire due entries, holding one result back to mark the final one
          stt_pkg::OP_DISPATCH: begin
            state_d = last_step ? S_FLUSH : S_READ;
            if (eval.due) begin
              we_c = 1'b1;
              if (rdata_a.periodic) begin
                wdata_c.count = '0;
              end else begin
                wdata_c = rdata_b;
                tail_d  = idx_inc(tail_q);
                full_d  = 1'b0;
              end
              if (hold_valid_q) begin
                rv_d     = 1'b1;
                fid_d    = hold_id_q;
                fired_d  = 1'b1;
                status_d = hold_status_q;
              end
              hold_valid_d  = 1'b1;
              hold_id_d     = rdata_a.id;
              hold_status_d = eval.late ? stt_pkg::StTimeout : stt_pkg::StOk;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_FLUSH: begin
        pend_d  = 1'b0;
        rv_d    = 1'b1;
        last_d  = 1'b1;
        state_d = S_IDLE;
        if (hold_valid_q) begin
          fid_d        = hold_id_q;
          fired_d      = 1'b1;
          status_d     = hold_status_q;
          hold_valid_d = 1'b0;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      full_q       <= 1'b0;
      pend_q       <= 1'b0;
      hold_valid_q <= 1'b0;
      rv_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      full_q       <= full_d;
      pend_q       <= pend_d;
      hold_valid_q <= hold_valid_d;
      rv_q         <= rv_d;
    end
  end

  // walk and result payload registers
  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    slot_q        <= slot_d;
    rem_q         <= rem_d;
    id_q          <= id_d;
    hold_id_q     <= hold_id_d;
    hold_status_q <= hold_status_d;
    fid_q         <= fid_d;
    fired_q       <= fired_d;
    status_q      <= status_d;
    last_q        <= last_d;
  end

  assign result_valid_o = rv_q;
  assign fired_id_o     = fid_q;
  assign fired_o        = fired_q;
  assign status_o       = status_q;
  assign last_o         = last_q;

  // checks on the sequencer and ring
  `STT_ASSERT_NOW(a_full_ptrs, full_q, head_q == tail_q, "full ring with unequal pointers")
  `STT_ASSERT_NEXT(a_exec_once, state_q == S_EXEC, state_q != S_EXEC, "evaluate step repeated")
  `STT_ASSERT_NOW(a_read_left, state_q == S_READ, rem_q != '0, "walk read with no entry left")
  `STT_ASSERT_NOW(a_more_busy, result_valid_o && !last_o, busy, "non-final result while idle")

endmodule

[bench/testbench.sv]
// self-checking testbench for the software timer task table
`timescale 1ns / 1ps

module testbench;

  localparam int Depth = stt_pkg::MaxTasksDefault;
  localparam int unsigned IdW    = stt_pkg::IdW;
  localparam int unsigned DelayW = stt_pkg::DelayW;
  localparam int unsigned CountW = stt_pkg::CountW;
  localparam int unsigned StatW  = stt_pkg::StatW;
  // about 150 transactions, each a walk of at most the ring depth, plus gaps
  localparam int CycleLimit = 20_000;
  localparam int DrainCycles = 4 * Depth + 20;
  localparam int GapPercent = 11;
  localparam int RandomItems = 120;

  // one command transaction as queued for the driver
  typedef struct {
    stt_pkg::stt_op_e  op;
    logic [IdW-1:0]    id;
    logic [DelayW-1:0] delay;
    logic              periodic;
    bit                drain;
    bit                no_gap;
  } timer_cmd_t;

  // one result transaction
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic             fired;
    logic [StatW-1:0] status;
    logic             last;
  } timer_result_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        operation_i = stt_pkg::OP_TICK;
  logic [IdW-1:0]    task_id_i = '0;
  logic [DelayW-1:0] delay_ticks_i = '0;
  logic              periodic_i = 1'b0;
  logic              result_valid_o;
  logic [IdW-1:0]    fired_id_o;
  logic              fired_o;
  logic [StatW-1:0]  status_o;
  logic              last_o;

  timer_cmd_t    cmd_q [$];
  timer_cmd_t    cur_cmd;
  timer_result_t timer_results_q [$];
  int            results_due = 0;
  int            results_seen = 0;
  int            mismatches = 0;
  int            cycle_count = 0;

  // shadow copy of the timer ring
  logic [IdW-1:0]    tbl_id [Depth];
  logic [DelayW-1:0] tbl_delay [Depth];
  logic              tbl_periodic [Depth];
  logic [CountW-1:0] tbl_count [Depth];
  int                tbl_head = 0;
  int                tbl_tail = 0;
  bit                tbl_full = 1'b0;
  bit                tbl_tick_pend = 1'b0;

  software_timer_task_table #(
    .MAX_TASKS(Depth)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .task_id_i     (task_id_i),
    .delay_ticks_i (delay_ticks_i),
    .periodic_i    (periodic_i),
    .result_valid_o(result_valid_o),
    .fired_id_o    (fired_id_o),
    .fired_o       (fired_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // mismatch reporting
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("mismatch: %s got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    end
  endtask

  // remove slot s: the tail entry takes its place and the tail advances
  function automatic void drop_entry(input int s);
    tbl_id[s]       = tbl_id[tbl_tail];
    tbl_delay[s]    = tbl_delay[tbl_tail];
    tbl_periodic[s] = tbl_periodic[tbl_tail];
    tbl_count[s]    = tbl_count[tbl_tail];
    tbl_tail        = (tbl_tail + 1) % Depth;
    tbl_full        = 1'b0;
  endfunction

  // apply one command to the shadow ring and queue the results it causes
  task automatic step_timer_table(input timer_cmd_t c, output int n_res);
    int            n;
    int            t0;
    int            s;
    logic [StatW-1:0] st;
    timer_result_t r;
    timer_result_t res [$];
    n  = tbl_full ? Depth : (tbl_head - tbl_tail + Depth) % Depth;
    t0 = tbl_tail;
    r  = '0;
    case (c.op)
      stt_pkg::OP_START: begin
        if (tbl_full) begin
          r.status = stt_pkg::StFull;
        end else begin
          tbl_id[tbl_head]       = c.id;
          tbl_delay[tbl_head]    = c.delay;
          tbl_periodic[tbl_head] = c.periodic;
          tbl_count[tbl_head]    = '0;
          tbl_head = (tbl_head + 1) % Depth;
          tbl_full = (tbl_head == tbl_tail);
          r.status = stt_pkg::StOk;
        end
        res.push_back(r);
      end
      stt_pkg::OP_STOP: begin
        st = stt_pkg::StNotFound;
        for (int k = 0; k < n; k++) begin
          s = (t0 + k) % Depth;
          if (st == stt_pkg::StNotFound && tbl_id[s] == c.id) begin
            drop_entry(s);
            st = stt_pkg::StOk;
          end
        end
        r.status = st;
        res.push_back(r);
      end
      stt_pkg::OP_TICK: begin
        for (int k = 0; k < n; k++) begin
          s = (t0 + k) % Depth;
          if (tbl_count[s] != stt_pkg::CountMax) tbl_count[s] = tbl_count[s] + 1'b1;
        end
        tbl_tick_pend = 1'b1;
        r.status = stt_pkg::StOk;
        res.push_back(r);
      end
      stt_pkg::OP_DISPATCH: begin
        if (!tbl_tick_pend) begin
          r.status = stt_pkg::StOk;
          res.push_back(r);
        end else if (n == 0) begin
          tbl_tick_pend = 1'b0;
          r.status = stt_pkg::StEmpty;
          res.push_back(r);
        end else begin
          // oldest to newest; a moved tail entry is not visited twice
          for (int k = 0; k < n; k++) begin
            s = (t0 + k) % Depth;
            if (int'(tbl_count[s]) >= int'(tbl_delay[s])) begin
              r        = '0;
              r.fired  = 1'b1;
              r.id     = tbl_id[s];
              r.status = (int'(tbl_count[s]) > 2 * int'(tbl_delay[s])) ? stt_pkg::StTimeout
                                                                       : stt_pkg::StOk;
              tbl_count[s] = '0;
              if (!tbl_periodic[s]) drop_entry(s);
              res.push_back(r);
            end
          end
          if (res.size() == 0) begin
            r = '0;
            r.status = stt_pkg::StOk;
            res.push_back(r);
          end
          tbl_tick_pend = 1'b0;
        end
      end
    endcase
    r = res.pop_back();
    r.last = 1'b1;
    res.push_back(r);
    foreach (res[i]) timer_results_q.push_back(res[i]);
    n_res = res.size();
  endtask

  function automatic void add_cmd(input stt_pkg::stt_op_e op, input logic [IdW-1:0] id,
                                  input logic [DelayW-1:0] delay, input logic periodic,
                                  input bit drain, input bit no_gap);
    timer_cmd_t c;
    c.op       = op;
    c.id       = id;
    c.delay    = delay;
    c.periodic = periodic;
    c.drain    = drain;
    c.no_gap   = no_gap;
    cmd_q.push_back(c);
  endfunction

  // driver: present queued commands, predict on each accepted transaction
  always @(posedge clk_i) begin : driver
    timer_cmd_t c;
    int         n_res;
    if (rst_ni) begin
      if (start && !busy) begin
        step_timer_table(cur_cmd, n_res);
        results_due <= results_due + n_res;
      end
      if (!start || !busy) begin
        if (cmd_q.size() != 0 &&
            (cmd_q[0].no_gap || $urandom_range(99) >= GapPercent) &&
            (!cmd_q[0].drain || (!start && results_due == results_seen))) begin
          c = cmd_q.pop_front();
          cur_cmd       <= c;
          operation_i   <= c.op;
          task_id_i     <= c.id;
          delay_ticks_i <= c.delay;
          periodic_i    <= c.periodic;
          start         <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : monitor
    timer_result_t want;
    if (rst_ni && result_valid_o) begin
      results_seen <= results_seen + 1;
      if (timer_results_q.size() == 0) begin
        report_mismatch("result with nothing outstanding, fired_id", fired_id_o, 0);
      end else begin
        want = timer_results_q.pop_front();
        if (fired_id_o !== want.id) report_mismatch("fired_id", fired_id_o, want.id);
        if (fired_o !== want.fired) report_mismatch("fired", fired_o, want.fired);
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int r;
    timer_cmd_t c;
    for (int i = 0; i < Depth; i++) begin
      tbl_id[i]       = '0;
      tbl_delay[i]    = '0;
      tbl_periodic[i] = 1'b0;
      tbl_count[i]    = '0;
    end

    // directed: idle dispatch, empty ring, zero delay, extremes of fields
    add_cmd(stt_pkg::OP_DISPATCH, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_cmd(stt_pkg::OP_TICK,     8'h00, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_cmd(stt_pkg::OP_DISPATCH, 8'hff, 16'hffff, 1'b1, 1'b0, 1'b0);
    add_cmd(stt_pkg::OP_STOP,     8'h12, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_cmd(stt_pkg::OP_START,    8'h00, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_cmd(stt_pkg::OP_START,    8'hff, 16'hffff, 1'b1, 1'b0, 1'b0);
    add_cmd(stt_pkg::OP_START,    8'ha5, 16'h0001, 1'b1, 1'b0, 1'b0);
    add_cmd(stt_pkg::OP_TICK,     8'h00, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_cmd(stt_pkg::OP_DISPATCH, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0);
    // late firing: counter above twice its delay
    repeat (3) add_cmd(stt_pkg::OP_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_cmd(stt_pkg::OP_DISPATCH, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0);
    // stop that matches, then the same id again
    add_cmd(stt_pkg::OP_STOP,     8'hff, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_cmd(stt_pkg::OP_STOP,     8'hff, 16'h0000, 1'b0, 1'b0, 1'b0);
    // fill the ring, reject one more, fire every entry in one dispatch
    for (int k = 1; k < Depth; k++) begin
      add_cmd(stt_pkg::OP_START, IdW'(k), DelayW'(k % 2), 1'b0, 1'b0, 1'b0);
    end
    add_cmd(stt_pkg::OP_START,    8'h5a, 16'h0003, 1'b1, 1'b0, 1'b0);
    add_cmd(stt_pkg::OP_TICK,     8'h00, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_cmd(stt_pkg::OP_DISPATCH, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0);

    // random mix, mostly small ids and delays so stops match and entries fire
    for (int i = 0; i < RandomItems; i++) begin
      r = $urandom_range(99);
      if (r < 30) c.op = stt_pkg::OP_START;
      else if (r < 45) c.op = stt_pkg::OP_STOP;
      else if (r < 75) c.op = stt_pkg::OP_TICK;
      else c.op = stt_pkg::OP_DISPATCH;
      c.id       = ($urandom_range(9) == 0) ? IdW'($urandom) : IdW'($urandom_range(1, 6));
      c.delay    = ($urandom_range(9) == 0) ? DelayW'($urandom)
                                            : DelayW'($urandom_range(0, 5));
      c.periodic = $urandom_range(1);
      c.drain    = (i == 0 || i == RandomItems / 2);
      c.no_gap   = (i >= 60 && i < 100);
      cmd_q.push_back(c);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for all transactions and results, then let the block settle
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || start || results_due != results_seen);
    repeat (DrainCycles) @(posedge clk_i);
    if (timer_results_q.size() != 0) begin
      report_mismatch("results never seen", 0, timer_results_q.size());
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
